// ===== design/assert_macros.svh =====
// Assertion macros used by the design file, clocked on aclk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== design/mrwt_pkg.sv =====
// Shared constants for the Miller-Rabin witness test block: verdict codes and bus widths.
package mrwt_pkg;

    localparam int FIELD_W   = 64;
    localparam int S_TDATA_W = 2 * FIELD_W;
    localparam int VERDICT_W = 2;
    localparam int M_TDATA_W = 8;

    localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INVALID   = 2'd2;

endpackage

// ===== design/miller_rabin_witness_test.sv =====
// One Miller-Rabin round on a candidate n and a witness a. Each item is answered with one
// verdict: probably prime, composite, or invalid (n even or below 5). All arithmetic runs on a
// single shift-add modular multiplier that retires one multiplier bit per cycle; the witness
// reduction also goes through it as 1 * a mod n. An item needs at most about 2 * WIDTH
// products, and the remaining factors of two are stripped from n - 1 before the power
// starts. An invalid candidate skips the multiplier and goes straight to its verdict.
// A new item is taken only after the verdict has been delivered. Only the low WIDTH bits of
// each input field are used.
`include "assert_macros.svh"

module miller_rabin_witness_test import mrwt_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [63:0] candidate, [127:64] witness
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [1:0] verdict, upper bits zero
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_NEXT, S_SPLIT, S_POW, S_CHECK, S_LOOP, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_REDUCE, PH_POWMUL, PH_POWSQR, PH_SQR
    } phase_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [WIDTH-1:0]     n_reg, n_next;
    logic [WIDTH-1:0]     nm1_reg, nm1_next;
    logic [WIDTH-1:0]     e_reg, e_next;
    logic [WIDTH-1:0]     acc_reg, acc_next;
    logic [WIDTH-1:0]     base_reg, base_next;
    logic [WIDTH-1:0]     mul_a_reg, mul_a_next;
    logic [WIDTH-1:0]     mul_b_reg, mul_b_next;
    logic [WIDTH-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     sq_left_reg, sq_left_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;

    logic [WIDTH-1:0] cand_in, wit_in;
    logic [WIDTH+1:0] sum, n_ext, n2_ext, diff1, diff2;
    logic [WIDTH-1:0] r_step;
    logic             s_accept, mul_last, invalid_out;

    assign cand_in = s_axis_tdata[WIDTH-1:0];
    assign wit_in  = s_axis_tdata[FIELD_W +: WIDTH];

    // One multiplier bit per cycle: r = (2r + bit * a) mod n. Since r, a < n the sum stays
    // below 3n, so one of two parallel subtractions brings it back into range.
    always_comb begin
        sum    = {1'b0, r_reg, 1'b0} + (mul_b_reg[WIDTH-1] ? {2'b00, mul_a_reg} : '0);
        n_ext  = {2'b00, n_reg};
        n2_ext = {1'b0, n_reg, 1'b0};
        diff1  = sum - n_ext;
        diff2  = sum - n2_ext;
        if (sum >= n2_ext) begin
            r_step = diff2[WIDTH-1:0];
        end else if (sum >= n_ext) begin
            r_step = diff1[WIDTH-1:0];
        end else begin
            r_step = sum[WIDTH-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        sq_left_next = sq_left_reg;
        verdict_next = verdict_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_next       = cand_in;
                    nm1_next     = cand_in - WIDTH'(1);
                    // n is odd, so (n - 1) / 2 is n shifted right; that accounts for one factor.
                    e_next       = cand_in >> 1;
                    sq_left_next = '0;
                    if (!cand_in[0] || cand_in < WIDTH'(5)) begin
                        verdict_next = VERDICT_INVALID;
                        state_next   = S_DONE;
                    end else begin
                        mul_a_next = WIDTH'(1);
                        mul_b_next = wit_in;
                        r_next     = '0;
                        cnt_next   = CNT_W'(WIDTH - 1);
                        phase_next = PH_REDUCE;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                r_next     = r_step;
                mul_b_next = mul_b_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = S_NEXT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_NEXT: begin
                unique case (phase_reg)
                    PH_REDUCE: begin
                        if (r_reg == '0) begin
                            verdict_next = VERDICT_PRIME;
                            state_next   = S_DONE;
                        end else begin
                            base_next  = r_reg;
                            acc_next   = WIDTH'(1);
                            state_next = S_SPLIT;
                        end
                    end
                    PH_POWMUL: begin
                        acc_next   = r_reg;
                        e_next     = {e_reg[WIDTH-1:1], 1'b0};
                        state_next = S_POW;
                    end
                    PH_POWSQR: begin
                        base_next  = r_reg;
                        e_next     = e_reg >> 1;
                        state_next = S_POW;
                    end
                    PH_SQR: begin
                        acc_next     = r_reg;
                        sq_left_next = sq_left_reg - CNT_W'(1);
                        if (r_reg == nm1_reg) begin
                            verdict_next = VERDICT_PRIME;
                            state_next   = S_DONE;
                        end else if (r_reg == WIDTH'(1)) begin
                            verdict_next = VERDICT_COMPOSITE;
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_LOOP;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SPLIT: begin
                if (e_reg[0]) begin
                    state_next = S_POW;
                end else begin
                    e_next       = e_reg >> 1;
                    sq_left_next = sq_left_reg + CNT_W'(1);
                end
            end
            S_POW: begin
                // Square-and-multiply from the low exponent bit; the base is squared only
                // while higher exponent bits remain.
                if (e_reg == '0) begin
                    state_next = S_CHECK;
                end else begin
                    r_next     = '0;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    state_next = S_MUL;
                    if (e_reg[0]) begin
                        mul_a_next = acc_reg;
                        mul_b_next = base_reg;
                        phase_next = PH_POWMUL;
                    end else begin
                        mul_a_next = base_reg;
                        mul_b_next = base_reg;
                        phase_next = PH_POWSQR;
                    end
                end
            end
            S_CHECK: begin
                if (acc_reg == WIDTH'(1) || acc_reg == nm1_reg) begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = S_DONE;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (sq_left_reg == '0) begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = S_DONE;
                end else begin
                    mul_a_next = acc_reg;
                    mul_b_next = acc_reg;
                    r_next     = '0;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    phase_next = PH_SQR;
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_REDUCE;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
        n_reg       <= n_next;
        nm1_reg     <= nm1_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        sq_left_reg <= sq_left_next;
        verdict_reg <= verdict_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_DONE);
    assign m_axis_tdata  = {{(M_TDATA_W - VERDICT_W){1'b0}}, verdict_reg};

    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign mul_last    = (state_reg == S_MUL) && (cnt_reg == '0);
    assign invalid_out = m_axis_tvalid && (verdict_reg == VERDICT_INVALID);

    `ASSERT_NEVER(a_busy_both_sides, s_axis_tready && m_axis_tvalid, "input and output both open")
    `ASSERT_CLK(a_partial_below_n, state_reg == S_MUL |-> r_reg < n_reg, "product escaped range")
    `ASSERT_CLK(a_invalid_fast, s_accept && !cand_in[0] |=> invalid_out, "even candidate kept")
    `ASSERT_CLK(a_mul_ends, mul_last |=> state_reg == S_NEXT, "multiplier did not finish")

endmodule

// ===== tb/miller_rabin_witness_test_tb.sv =====
// Testbench for the Miller-Rabin witness test block: stream driver, verdict predictor, checker.
`timescale 1ns / 100ps

module miller_rabin_witness_test_tb;
    import mrwt_pkg::*;

    localparam int RANDOM_ITEMS = 77;
    localparam int CYCLES_PER_ITEM_LIMIT = 40000;

    typedef logic [VERDICT_W-1:0] verdict_t;

    typedef struct {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] witness;
        bit                 drain_first;
    } round_item_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // [63:0] candidate, [127:64] witness
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [1:0] verdict, upper bits zero

    round_item_t pending_items[$];
    verdict_t    expected_verdicts[$];
    int          total_items;
    int          items_accepted = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          cycle_limit = 32'h7fff_ffff;
    bit          s_fire = 1'b0;

    miller_rabin_witness_test i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // A 128-bit product keeps every intermediate exact, so a plain remainder gives a*b mod n.
    function automatic logic [63:0] modular_product(input logic [63:0] a, input logic [63:0] b,
                                                    input logic [63:0] n);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return 64'(wide % {64'd0, n});
    endfunction

    function automatic logic [63:0] modular_power(input logic [63:0] base, input logic [63:0] e,
                                                  input logic [63:0] n);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 64'd0) begin
            if (e[0])
                acc = modular_product(acc, base, n);
            base = modular_product(base, base, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic verdict_t miller_rabin_verdict(input logic [63:0] n, input logic [63:0] w);
        logic [63:0] n_minus_1;
        logic [63:0] odd_part;
        logic [63:0] x;
        logic [63:0] a;
        int          twos;
        if (!n[0] || n < 64'd5)
            return VERDICT_INVALID;
        a = w % n;
        if (a == 64'd0)
            return VERDICT_PRIME;
        n_minus_1 = n - 64'd1;
        odd_part = n_minus_1;
        twos = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        x = modular_power(a, odd_part, n);
        if (x == 64'd1 || x == n_minus_1)
            return VERDICT_PRIME;
        for (int r = 1; r < twos; r++) begin
            x = modular_product(x, x, n);
            if (x == n_minus_1)
                return VERDICT_PRIME;
            if (x == 64'd1)
                return VERDICT_COMPOSITE;
        end
        return VERDICT_COMPOSITE;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Odd number with exactly the given bit length, at least 5.
    function automatic logic [63:0] random_odd(input int bits);
        logic [63:0] value;
        value = random_word() >> (64 - bits);
        value[bits-1] = 1'b1;
        value[0] = 1'b1;
        if (value < 64'd5)
            value = 64'd5 + 64'(2 * $urandom_range(1));
        return value;
    endfunction

    task automatic add_item(input logic [63:0] candidate, input logic [63:0] witness,
                            input bit drain_first);
        round_item_t item;
        item.candidate = candidate;
        item.witness = witness;
        item.drain_first = drain_first;
        pending_items.push_back(item);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Input side: a new item may replace the current one only after it was taken.
    always @(negedge aclk) begin : drive_items
        int          sender_idle;
        round_item_t item;
        if (items_accepted * 3 < total_items)
            sender_idle = 34;
        else if (items_accepted * 3 < total_items * 2)
            sender_idle = 55;
        else
            sender_idle = 0;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (pending_items.size() != 0
                && !(pending_items[0].drain_first && expected_verdicts.size() != 0)
                && $urandom_range(99) >= sender_idle) begin
                item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {item.witness, item.candidate};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_ready
        int receiver_idle;
        if (items_accepted * 3 < total_items)
            receiver_idle = 55;
        else if (items_accepted * 3 < total_items * 2)
            receiver_idle = 34;
        else
            receiver_idle = 0;
        m_axis_tready <= aresetn && ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge aclk) begin : watch_channels
        verdict_t want;
        s_fire <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            expected_verdicts.push_back(miller_rabin_verdict(s_axis_tdata[63:0],
                                                             s_axis_tdata[127:64]));
            items_accepted <= items_accepted + 1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected verdict", 64'(m_axis_tdata[VERDICT_W-1:0]),
                                64'd0);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[VERDICT_W-1:0] !== want)
                    report_mismatch("verdict", 64'(m_axis_tdata[VERDICT_W-1:0]), 64'(want));
                if (m_axis_tdata[M_TDATA_W-1:VERDICT_W] !== '0)
                    report_mismatch("tdata padding",
                                    64'(m_axis_tdata[M_TDATA_W-1:VERDICT_W]), 64'd0);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= cycle_limit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_test
        logic [63:0] known_numbers[12];
        logic [63:0] n;
        logic [63:0] w;
        int          pick;
        known_numbers = '{64'd18446744073709551557, 64'd9223372036854775783,
                          64'd2305843009213693951, 64'd4294967291, 64'd1000000007,
                          64'd998244353, 64'd65521, 64'd3215031751, 64'd1373653,
                          64'd2047, 64'd561, 64'd1105};

        // Directed: tiny and even candidates, reduced witness zero, witness one and n - 1,
        // strong pseudoprimes, and a Carmichael number whose squares hit one early.
        add_item(64'd0, 64'd0, 1'b0);
        add_item(64'd1, 64'd1, 1'b0);
        add_item(64'd2, 64'd5, 1'b0);
        add_item(64'd3, '1, 1'b0);
        add_item(64'd4, 64'd3, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFE, random_word(), 1'b0);
        add_item(64'd5, 64'd0, 1'b0);
        add_item(64'd5, 64'd5, 1'b0);
        add_item(64'd7, 64'd14, 1'b0);
        add_item('1, 64'd2, 1'b0);
        add_item(64'd18446744073709551557, 64'd2, 1'b0);
        add_item(64'd18446744073709551557, 64'd18446744073709551556, 1'b0);
        add_item(64'd18446744073709551557, 64'd1, 1'b0);
        add_item(64'd18446744073709551557, '1, 1'b0);
        add_item(64'd561, 64'd2, 1'b0);
        add_item(64'd2047, 64'd2, 1'b0);
        add_item(64'd3215031751, 64'd2, 1'b0);
        add_item(64'd2305843009213693951, 64'd3, 1'b0);
        add_item(64'd1000000007, '1, 1'b0);
        add_item(64'd9, 64'd8, 1'b0);
        add_item(64'd25, 64'd7, 1'b0);
        add_item(64'd65537, 64'd3, 1'b0);
        add_item(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0);

        // Random: mostly valid odd candidates of every length, with known primes and
        // pseudoprimes mixed in, some special witnesses, and some invalid candidates.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                n = random_odd($urandom_range(64, 3));
                w = random_word();
            end else if (pick < 75) begin
                n = known_numbers[$urandom_range(11)];
                w = random_word();
            end else if (pick < 85) begin
                n = random_odd($urandom_range(64, 3));
                case ($urandom_range(3))
                    0: w = 64'd1;
                    1: w = n - 64'd1;
                    2: w = n;
                    default: w = 64'd0;
                endcase
            end else if (pick < 93) begin
                n = random_word();
                n[0] = 1'b0;
                w = random_word();
            end else begin
                n = 64'($urandom_range(4));
                w = random_word();
            end
            add_item(n, w, (i % 20) == 0);
        end

        total_items = pending_items.size();
        cycle_limit = total_items * CYCLES_PER_ITEM_LIMIT + 10000;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== miller_rabin_witness_test.f =====
+incdir+design
design/mrwt_pkg.sv
design/miller_rabin_witness_test.sv
tb/miller_rabin_witness_test_tb.sv
